[rtl/core/npef_pkg.sv]
// ----------------------------------------------------------------------------
// npef_pkg
// shared types and constants of the nearest polygon edge finder
// ----------------------------------------------------------------------------
`default_nettype none

package npef_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int VCOUNT_BITS      = 7;
  localparam int INDEX_BITS       = 6;
  localparam int VCOUNT_MIN       = 3;
  localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_LDB,
    S_DIFF,
    S_PAIR,
    S_STORE,
    S_CMP,
    S_LIMB,
    S_LDONE,
    S_NEXT,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PR_LEN,
    PR_DOTB,
    PR_DOTA,
    PR_PB2,
    PR_PA2,
    PR_CROSS
  } pair_t;

  typedef enum logic {
    MD_SQ,
    MD_CMP
  } mode_t;

endpackage

`default_nettype wire

[rtl/core/npef_ram.sv]
// ----------------------------------------------------------------------------
// npef_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module npef_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/nearest_polygon_edge_finder.sv]
// ----------------------------------------------------------------------------
// nearest_polygon_edge_finder
// vertex table plus nearest edge search for a query point
// ----------------------------------------------------------------------------
// A write item (op 0) stores one vertex. A query item (op 1) walks the
// closing edge and then every other edge once, using one shared signed
// multiplier and one wide accumulator under a sequencer; the result is the
// insertion index after the nearest edge, with the vertex count meaning the
// closing edge. For each edge the sequencer loads the vertex and forms the
// differences, forms the three dot products, then an endpoint distance or
// the squared cross product, then the exact cross-multiplied compare done
// in limbs on the multiplier where needed, and steps to the next edge. A
// query is accepted, reads two table entries, runs these steps per edge and
// then presents the result; the block takes no item until the result is
// taken. Unwritten vertex slots read as undefined values.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_polygon_edge_finder #(
  parameter int MAX_VERTICES = npef_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = npef_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_op,
  input  wire logic [npef_pkg::INDEX_BITS-1:0] in_vertex_index,
  input  wire logic signed [COORD_BITS-1:0]  in_x,
  input  wire logic signed [COORD_BITS-1:0]  in_y,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [npef_pkg::VCOUNT_BITS-1:0] out_insert_index,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [npef_pkg::VCOUNT_BITS-1:0] cfg_data
);
  import npef_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int D     = C + 1;
  localparam int H     = C + 1;
  localparam int M     = C + 2;
  localparam int P     = 2 * M;
  localparam int ACC_W = 6 * H + 1;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int NB    = $clog2(MAX_VERTICES + 1);
  localparam int NW    = (NB > VCOUNT_BITS) ? NB : VCOUNT_BITS;

  state_t state_r, state_nxt;
  logic [VCOUNT_BITS-1:0] vc_r, vc_nxt;
  logic signed [C-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [C-1:0] ax_r, ax_nxt, ay_r, ay_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic signed [D-1:0] abx_r, abx_nxt, aby_r, aby_nxt;
  logic signed [D-1:0] pbx_r, pbx_nxt, pby_r, pby_nxt;
  logic signed [D-1:0] pax_r, pax_nxt, pay_r, pay_nxt;
  logic [NW-1:0] n_r, n_nxt, k_r, k_nxt, best_idx_r, best_idx_nxt;
  logic first_r, first_nxt;
  logic signed [P-1:0] p_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  pair_t pr_r, pr_nxt;
  logic [1:0] t_r, t_nxt;
  logic [2*H-1:0] len_r, len_nxt, mag_r, mag_nxt;
  logic lenz_r, lenz_nxt, dotb_r, dotb_nxt;
  logic [4*H-1:0] cur_num_r, cur_num_nxt, best_num_r, best_num_nxt;
  logic [2*H-1:0] cur_den_r, cur_den_nxt, best_den_r, best_den_nxt;
  logic cur_inf_r, cur_inf_nxt, best_inf_r, best_inf_nxt;
  mode_t mode_r, mode_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic pv_r, pv_nxt, pneg_r, pneg_nxt;
  logic [2:0] psh_r, psh_nxt;

  logic signed [M-1:0] mul_a, mul_b;
  logic signed [P-1:0] mul_p;
  logic acc_we, acc_from_zero, acc_neg;
  logic signed [ACC_W-1:0] acc_add, acc_base, acc_sum;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2*C-1:0] ram_rdata;
  logic signed [C-1:0] rd_x, rd_y;
  logic [NW-1:0] idx_n, vc_n, nm1, kn;
  logic [4*H-1:0] xv;
  logic [2*H-1:0] yv;
  logic [1:0] xi;
  logic yj;
  logic [4:0] total;
  logic [H-1:0] limb_x, limb_y;
  logic signed [ACC_W-1:0] acc_abs;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_insert_index = best_idx_r[VCOUNT_BITS-1:0];
  assign cfg_ready        = 1'b1;

  assign idx_n     = NW'(in_vertex_index);
  assign ram_we    = in_valid && in_ready && (in_op == OP_WRITE) &&
                     (idx_n < NW'(MAX_VERTICES));
  assign ram_waddr = idx_n[AW-1:0];
  assign rd_x      = ram_rdata[2*C-1:C];
  assign rd_y      = ram_rdata[C-1:0];
  assign vc_n      = NW'(vc_r);
  assign nm1       = n_r - NW'(1);
  assign kn        = k_r + NW'(1);

  npef_ram #(
    .WIDTH(2 * C),
    .DEPTH(MAX_VERTICES)
  ) u_vtx_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({in_x, in_y}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared arithmetic unit
  assign mul_p    = mul_a * mul_b;
  assign acc_base = acc_from_zero ? '0 : acc_r;
  assign acc_sum  = acc_base + (acc_neg ? -acc_add : acc_add);
  assign acc_abs  = acc_r[ACC_W-1] ? -acc_r : acc_r;

  // limb selection for the wide products
  assign xi    = cnt_r[2:1];
  assign yj    = cnt_r[0];
  assign total = (mode_r == MD_SQ) ? 5'd8 : 5'd16;
  always_comb begin
    if (mode_r == MD_SQ) begin
      xv = {{(2*H){1'b0}}, mag_r};
      yv = mag_r;
    end else if (!cnt_r[3]) begin
      xv = cur_num_r;
      yv = best_den_r;
    end else begin
      xv = best_num_r;
      yv = cur_den_r;
    end
  end
  assign limb_x = xv[xi*H +: H];
  assign limb_y = yv[yj*H +: H];

  always_comb begin
    state_nxt    = state_r;
    vc_nxt       = vc_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    ax_nxt       = ax_r;
    ay_nxt       = ay_r;
    bx_nxt       = bx_r;
    by_nxt       = by_r;
    abx_nxt      = abx_r;
    aby_nxt      = aby_r;
    pbx_nxt      = pbx_r;
    pby_nxt      = pby_r;
    pax_nxt      = pax_r;
    pay_nxt      = pay_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    best_idx_nxt = best_idx_r;
    first_nxt    = first_r;
    pr_nxt       = pr_r;
    t_nxt        = t_r;
    len_nxt      = len_r;
    mag_nxt      = mag_r;
    lenz_nxt     = lenz_r;
    dotb_nxt     = dotb_r;
    cur_num_nxt  = cur_num_r;
    cur_den_nxt  = cur_den_r;
    cur_inf_nxt  = cur_inf_r;
    best_num_nxt = best_num_r;
    best_den_nxt = best_den_r;
    best_inf_nxt = best_inf_r;
    mode_nxt     = mode_r;
    cnt_nxt      = cnt_r;
    pv_nxt       = 1'b0;
    pneg_nxt     = pneg_r;
    psh_nxt      = psh_r;
    acc_nxt      = acc_r;
    mul_a        = '0;
    mul_b        = '0;
    acc_we       = 1'b0;
    acc_from_zero = 1'b0;
    acc_neg      = 1'b0;
    acc_add      = '0;
    ram_raddr    = '0;

    if (cfg_valid && cfg_ready) begin
      vc_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_op == OP_QUERY) begin
          px_nxt    = in_x;
          py_nxt    = in_y;
          first_nxt = 1'b1;
          k_nxt     = '0;
          if (vc_n < NW'(VCOUNT_MIN)) begin
            n_nxt = NW'(VCOUNT_MIN);
          end else if (vc_n > NW'(MAX_VERTICES)) begin
            n_nxt = NW'(MAX_VERTICES);
          end else begin
            n_nxt = vc_n;
          end
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        ram_raddr = nm1[AW-1:0];
        state_nxt = S_RDB;
      end
      S_RDB: begin
        ax_nxt    = rd_x;
        ay_nxt    = rd_y;
        ram_raddr = '0;
        state_nxt = S_LDB;
      end
      S_LDB: begin
        bx_nxt    = rd_x;
        by_nxt    = rd_y;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        abx_nxt   = D'(bx_r) - D'(ax_r);
        aby_nxt   = D'(by_r) - D'(ay_r);
        pbx_nxt   = D'(px_r) - D'(bx_r);
        pby_nxt   = D'(py_r) - D'(by_r);
        pax_nxt   = D'(px_r) - D'(ax_r);
        pay_nxt   = D'(py_r) - D'(ay_r);
        pr_nxt    = PR_LEN;
        t_nxt     = 2'd0;
        state_nxt = S_PAIR;
      end
      S_PAIR: begin
        case (pr_r)
          PR_LEN: begin
            mul_a = (t_r == 2'd0) ? M'(abx_r) : M'(aby_r);
            mul_b = mul_a;
          end
          PR_DOTB: begin
            mul_a = (t_r == 2'd0) ? M'(abx_r) : M'(aby_r);
            mul_b = (t_r == 2'd0) ? M'(pbx_r) : M'(pby_r);
          end
          PR_DOTA: begin
            mul_a = (t_r == 2'd0) ? M'(abx_r) : M'(aby_r);
            mul_b = (t_r == 2'd0) ? M'(pax_r) : M'(pay_r);
          end
          PR_PB2: begin
            mul_a = (t_r == 2'd0) ? M'(pbx_r) : M'(pby_r);
            mul_b = mul_a;
          end
          PR_PA2: begin
            mul_a = (t_r == 2'd0) ? M'(pax_r) : M'(pay_r);
            mul_b = mul_a;
          end
          PR_CROSS: begin
            mul_a = (t_r == 2'd0) ? M'(abx_r) : M'(aby_r);
            mul_b = (t_r == 2'd0) ? M'(pay_r) : M'(pax_r);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        acc_add = ACC_W'(p_r);
        case (t_r)
          2'd0: begin
            t_nxt = 2'd1;
          end
          2'd1: begin
            acc_we        = 1'b1;
            acc_from_zero = 1'b1;
            t_nxt         = 2'd2;
          end
          default: begin
            acc_we    = 1'b1;
            acc_neg   = (pr_r == PR_CROSS);
            t_nxt     = 2'd0;
            state_nxt = S_STORE;
          end
        endcase
      end
      S_STORE: begin
        case (pr_r)
          PR_LEN: begin
            len_nxt   = acc_r[2*H-1:0];
            lenz_nxt  = (acc_r == '0);
            pr_nxt    = PR_DOTB;
            state_nxt = S_PAIR;
          end
          PR_DOTB: begin
            dotb_nxt  = !acc_r[ACC_W-1] && (acc_r != '0);
            pr_nxt    = PR_DOTA;
            state_nxt = S_PAIR;
          end
          PR_DOTA: begin
            if (lenz_r) begin
              cur_inf_nxt = 1'b1;
              state_nxt   = S_CMP;
            end else if (dotb_r) begin
              pr_nxt    = PR_PB2;
              state_nxt = S_PAIR;
            end else if (acc_r[ACC_W-1]) begin
              pr_nxt    = PR_PA2;
              state_nxt = S_PAIR;
            end else begin
              pr_nxt    = PR_CROSS;
              state_nxt = S_PAIR;
            end
          end
          PR_CROSS: begin
            mag_nxt       = acc_abs[2*H-1:0];
            mode_nxt      = MD_SQ;
            cnt_nxt       = '0;
            acc_we        = 1'b1;
            acc_from_zero = 1'b1;
            state_nxt     = S_LIMB;
          end
          default: begin
            cur_num_nxt = (4*H)'(acc_r[2*H-1:0]);
            cur_den_nxt = (2*H)'(1);
            cur_inf_nxt = 1'b0;
            state_nxt   = S_CMP;
          end
        endcase
      end
      S_CMP: begin
        if (first_r || (best_inf_r && !cur_inf_r)) begin
          best_num_nxt = cur_num_r;
          best_den_nxt = cur_den_r;
          best_inf_nxt = cur_inf_r;
          best_idx_nxt = first_r ? n_r : k_r;
          state_nxt    = S_NEXT;
        end else if (cur_inf_r) begin
          state_nxt = S_NEXT;
        end else begin
          mode_nxt      = MD_CMP;
          cnt_nxt       = '0;
          acc_we        = 1'b1;
          acc_from_zero = 1'b1;
          state_nxt     = S_LIMB;
        end
      end
      S_LIMB: begin
        mul_a   = $signed({1'b0, limb_x});
        mul_b   = $signed({1'b0, limb_y});
        acc_add = ACC_W'(p_r) <<< (psh_r * H);
        acc_neg = pneg_r;
        acc_we  = pv_r;
        if (cnt_r < total) begin
          pv_nxt   = 1'b1;
          psh_nxt  = {1'b0, xi} + {2'b00, yj};
          pneg_nxt = cnt_r[3];
          cnt_nxt  = cnt_r + 5'd1;
        end else begin
          state_nxt = S_LDONE;
        end
      end
      S_LDONE: begin
        if (mode_r == MD_SQ) begin
          cur_num_nxt = acc_r[4*H-1:0];
          cur_den_nxt = len_r;
          cur_inf_nxt = 1'b0;
          state_nxt   = S_CMP;
        end else begin
          if (acc_r[ACC_W-1]) begin
            best_num_nxt = cur_num_r;
            best_den_nxt = cur_den_r;
            best_inf_nxt = 1'b0;
            best_idx_nxt = k_r;
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        ram_raddr = kn[AW-1:0];
        if (kn < n_r) begin
          k_nxt     = kn;
          first_nxt = 1'b0;
          ax_nxt    = bx_r;
          ay_nxt    = by_r;
          state_nxt = S_LDB;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (acc_we) begin
      acc_nxt = acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vc_r    <= VCOUNT_RESET;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vc_r    <= vc_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    abx_r      <= abx_nxt;
    aby_r      <= aby_nxt;
    pbx_r      <= pbx_nxt;
    pby_r      <= pby_nxt;
    pax_r      <= pax_nxt;
    pay_r      <= pay_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    best_idx_r <= best_idx_nxt;
    first_r    <= first_nxt;
    p_r        <= mul_p;
    acc_r      <= acc_nxt;
    pr_r       <= pr_nxt;
    t_r        <= t_nxt;
    len_r      <= len_nxt;
    mag_r      <= mag_nxt;
    lenz_r     <= lenz_nxt;
    dotb_r     <= dotb_nxt;
    cur_num_r  <= cur_num_nxt;
    cur_den_r  <= cur_den_nxt;
    cur_inf_r  <= cur_inf_nxt;
    best_num_r <= best_num_nxt;
    best_den_r <= best_den_nxt;
    best_inf_r <= best_inf_nxt;
    mode_r     <= mode_nxt;
    cnt_r      <= cnt_nxt;
    pneg_r     <= pneg_nxt;
    psh_r      <= psh_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result side open together");

  a_pv_in_limb: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(state_r) == S_LIMB)
    else $error("partial product pending outside limb phase");

  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (n_r >= NW'(VCOUNT_MIN)) && (n_r <= NW'(MAX_VERTICES)))
    else $error("vertex count out of range during query");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEXT) |-> (k_r < n_r))
    else $error("edge counter past vertex count");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (best_idx_r != '0) && (best_idx_r <= n_r))
    else $error("insert index out of range");

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// nearest polygon edge finder: vertex writes and nearest edge queries are
// driven over valid/ready with random gaps. Each query result is checked
// against a fixed index or an exact integer model of the segment distance
// search; the vertex count changes per phase, including out-of-range values.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import npef_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV         = MAX_VERTICES_DEF;
  localparam int CB         = COORD_BITS_DEF;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_LEN   = 600;
  localparam int N_DIR      = 19;
  localparam int N_PHASE    = 10;

  typedef struct {
    logic                  op;
    logic [INDEX_BITS-1:0] idx;
    logic signed [CB-1:0]  x;
    logic signed [CB-1:0]  y;
    int                    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_WRITE;
  logic [INDEX_BITS-1:0] in_vertex_index = '0;
  logic signed [CB-1:0] in_x = '0;
  logic signed [CB-1:0] in_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VCOUNT_BITS-1:0] out_insert_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [VCOUNT_BITS-1:0] cfg_data = '0;

  logic signed [CB-1:0] vert_x [NV];
  logic signed [CB-1:0] vert_y [NV];
  logic [NV-1:0] slot_written = '0;
  logic [VCOUNT_BITS-1:0] vcount_shadow = VCOUNT_RESET;
  int pending_index [$];
  int errors = 0;
  int results_seen = 0;
  int sent_items = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  bit calm = 1'b0;
  int quiet_cycles = 0;

  stim_row_t dir_rows [N_DIR];
  logic [VCOUNT_BITS-1:0] phase_count [N_PHASE] =
    '{7'd5, 7'd64, 7'd0, 7'd127, 7'd4, 7'd9, 7'd65, 7'd3, 7'd7, 7'd1};

  nearest_polygon_edge_finder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_vertex_index(in_vertex_index), .in_x(in_x), .in_y(in_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_insert_index(out_insert_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int edges_in_use();
    int n;
    n = vcount_shadow;
    if (n < VCOUNT_MIN) n = VCOUNT_MIN;
    if (n > NV) n = NV;
    return n;
  endfunction

  // squared distance as num/den, inf for a zero-length edge
  function automatic void seg_dist2(input longint px, input longint py,
                                    input longint ax, input longint ay,
                                    input longint bx, input longint by,
                                    output bit inf, output logic [127:0] num,
                                    output logic [127:0] den);
    longint abx, aby, len2, dot_b, dot_a, cr, dx, dy;
    logic [127:0] mag;
    abx = bx - ax;
    aby = by - ay;
    len2 = abx * abx + aby * aby;
    dot_b = abx * (px - bx) + aby * (py - by);
    dot_a = (-abx) * (px - ax) + (-aby) * (py - ay);
    inf = 1'b0;
    den = 128'd1;
    if (len2 == 0) begin
      inf = 1'b1;
      num = '0;
    end else if (dot_b > 0 || dot_a > 0) begin
      dx = (dot_b > 0) ? px - bx : px - ax;
      dy = (dot_b > 0) ? py - by : py - ay;
      num = 128'(dx * dx + dy * dy);
    end else begin
      cr = abx * (py - ay) - aby * (px - ax);
      mag = 128'(cr < 0 ? -cr : cr);
      num = mag * mag;
      den = 128'(len2);
    end
  endfunction

  function automatic int nearest_insert_index(input longint px, input longint py);
    int n, best_idx;
    bit best_inf, cur_inf, nearer;
    logic [127:0] best_num, best_den, cur_num, cur_den;
    n = edges_in_use();
    seg_dist2(px, py, vert_x[n-1], vert_y[n-1], vert_x[0], vert_y[0],
              best_inf, best_num, best_den);
    best_idx = n;
    for (int i = 0; i + 1 < n; i++) begin
      seg_dist2(px, py, vert_x[i], vert_y[i], vert_x[i+1], vert_y[i+1],
                cur_inf, cur_num, cur_den);
      if (cur_inf) nearer = 1'b0;
      else if (best_inf) nearer = 1'b1;
      else nearer = (cur_num * best_den) < (best_num * cur_den);
      if (nearer) begin
        best_inf = cur_inf;
        best_num = cur_num;
        best_den = cur_den;
        best_idx = i + 1;
      end
    end
    return best_idx & 8'h7f;
  endfunction

  function automatic logic signed [CB-1:0] rand_coord();
    logic signed [CB-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = -16'sd32768;
          1: v = 16'sd32767;
          2: v = 16'sd0;
          default: v = -16'sd1;
        endcase
      end
      1, 2: v = CB'($urandom_range(0, 40)) - 16'sd20;
      default: v = CB'($urandom());
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_item(input logic op, input logic [INDEX_BITS-1:0] idx,
                           input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                           input int want);
    if (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_vertex_index <= idx;
    in_x <= x;
    in_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    if (op == OP_WRITE) begin
      vert_x[idx] = x;
      vert_y[idx] = y;
      slot_written[idx] = 1'b1;
    end else begin
      pending_index.push_back(want < 0 ? nearest_insert_index(x, y) : want);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_index.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [VCOUNT_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vcount_shadow = v;
  endtask

  task automatic random_item();
    int n, gap_slot;
    n = edges_in_use();
    gap_slot = -1;
    for (int i = n - 1; i >= 0; i--)
      if (!slot_written[i]) gap_slot = i;
    if (gap_slot >= 0)
      send_item(OP_WRITE, INDEX_BITS'(gap_slot), rand_coord(), rand_coord(), -1);
    else if ($urandom_range(0, 99) < 45)
      send_item(OP_WRITE, INDEX_BITS'($urandom_range(0, NV - 1)), rand_coord(),
                rand_coord(), -1);
    else
      send_item(OP_QUERY, INDEX_BITS'($urandom()), rand_coord(), rand_coord(), -1);
  endtask

  // result side: random stalls plus one long hold
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_index.size() == 0) begin
          report_mismatch("result with nothing pending", out_insert_index, -1);
        end else begin
          int want;
          want = pending_index.pop_front();
          if (out_insert_index !== VCOUNT_BITS'(want))
            report_mismatch("insert_index", out_insert_index, want);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!pressure_done && results_seen >= 40) begin
        pressure_done = 1'b1;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int per_phase;
    for (int i = 0; i < NV; i++) begin
      vert_x[i] = '0;
      vert_y[i] = '0;
    end
    dir_rows = '{
      '{OP_WRITE, 6'd0, 16'sd0, 16'sd0, -1},
      '{OP_WRITE, 6'd1, 16'sd10, 16'sd0, -1},
      '{OP_WRITE, 6'd2, 16'sd0, 16'sd10, -1},
      '{OP_QUERY, 6'd0, 16'sd5, -16'sd5, 1},
      '{OP_QUERY, 6'd0, -16'sd5, 16'sd5, 3},
      '{OP_QUERY, 6'd0, 16'sd6, 16'sd6, 2},
      '{OP_QUERY, 6'd0, 16'sd0, 16'sd0, 3},
      '{OP_QUERY, 6'd0, 16'sd10, 16'sd0, 1},
      '{OP_WRITE, 6'd0, 16'sd7, 16'sd7, -1},
      '{OP_WRITE, 6'd1, 16'sd7, 16'sd7, -1},
      '{OP_WRITE, 6'd2, 16'sd7, 16'sd7, -1},
      '{OP_QUERY, 6'd0, 16'sd1, 16'sd2, 3},
      '{OP_WRITE, 6'd0, -16'sd32768, -16'sd32768, -1},
      '{OP_WRITE, 6'd1, 16'sd32767, -16'sd32768, -1},
      '{OP_WRITE, 6'd2, 16'sd32767, 16'sd32767, -1},
      '{OP_QUERY, 6'd0, -16'sd32768, 16'sd32767, 3},
      '{OP_QUERY, 6'd0, 16'sd0, -16'sd32768, 1},
      '{OP_QUERY, 6'd0, 16'sd32767, 16'sd0, 2},
      '{OP_QUERY, 6'd63, -16'sd32768, -16'sd32768, -1}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].x, dir_rows[i].y,
                dir_rows[i].want);

    foreach (phase_count[p]) begin
      drain_and_settle();
      write_vertex_count(phase_count[p]);
      per_phase = (edges_in_use() >= 32) ? 25 : 280;
      for (int k = 0; k < per_phase; k++) begin
        calm = (sent_items >= 700 && sent_items < 1000);
        random_item();
      end
    end
    calm = 1'b0;
    drain_and_settle();
    repeat (40) @(posedge clk);

    if (errors == 0 && pending_index.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/core/npef_pkg.sv
rtl/core/npef_ram.sv
rtl/core/nearest_polygon_edge_finder.sv
test/testbench.sv
